// ===== design/slc_pkg.sv =====
`default_nettype none

package slc_pkg;

   // Sequence counter default width and output width
   localparam int unsigned SEQ_BITS_DEFAULT = 16;
   localparam int unsigned SEQ_OUT_BITS     = 16;

   // Configuration register indexes and reset values
   localparam int unsigned CSR_INDEX_BITS = 1;
   localparam int unsigned CSR_DATA_BITS  = 8;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RETRY_PERIOD   = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GIVE_UP_PERIOD = 1'd1;
   localparam logic [CSR_DATA_BITS-1:0]  RETRY_PERIOD_RESET   = 8'd10;
   localparam logic [CSR_DATA_BITS-1:0]  GIVE_UP_PERIOD_RESET = 8'd60;

   // Stream bus widths
   localparam int unsigned REQ_TDATA_BITS = 8;
   localparam int unsigned REQ_TUSER_BITS = 4;
   localparam int unsigned RSP_TDATA_BITS = 32;

   // Event codes
   typedef enum logic [3:0] {
      REQ_CREATE        = 4'd0,
      REQ_CONNECT       = 4'd1,
      REQ_ADDED         = 4'd2,
      REQ_ACCEPTED      = 4'd3,
      REQ_REMOVED       = 4'd4,
      REQ_REJECTED      = 4'd5,
      REQ_SERVER_CLOSED = 4'd6,
      REQ_CLOSE         = 4'd7,
      REQ_TICK          = 4'd8,
      REQ_DESYNC        = 4'd9,
      REQ_TX_SLOT       = 4'd10,
      REQ_RX_PACKET     = 4'd11,
      REQ_RX_MISS       = 4'd12
   } req_kind_type;

   // Stream status codes
   typedef enum logic [2:0] {
      ST_CONNECTING    = 3'd0,
      ST_FAILED        = 3'd1,
      ST_ESTABLISHED   = 3'd2,
      ST_ACCEPT_WAIT   = 3'd3,
      ST_REMOTE_CLOSED = 3'd4,
      ST_REOPENED      = 3'd5,
      ST_CLOSE_WAIT    = 3'd6
   } status_type;

   localparam logic [2:0] START_STATUS_INVALID = 3'd7;

   // Management message kinds
   typedef enum logic [1:0] {
      SME_NONE    = 2'd0,
      SME_CONNECT = 2'd1,
      SME_CLOSED  = 2'd2
   } sme_type;

   // Redundancy levels
   localparam logic [2:0] RED_NONE            = 3'd0;
   localparam logic [2:0] RED_DOUBLE          = 3'd1;
   localparam logic [2:0] RED_DOUBLE_SPATIAL  = 3'd2;
   localparam logic [2:0] RED_TRIPLE          = 3'd3;
   localparam logic [2:0] RED_TRIPLE_SPATIAL  = 3'd4;

   // Slots per redundancy period
   localparam logic [1:0] SLOTS_ONE   = 2'd1;
   localparam logic [1:0] SLOTS_TWO   = 2'd2;
   localparam logic [1:0] SLOTS_THREE = 2'd3;

   typedef logic signed [8:0] timer_type;

   // One input transaction
   typedef struct packed {
      logic [3:0] req_type;
      logic       app_packet_ready;
      logic [2:0] redundancy_level;
      logic [2:0] start_status;
   } req_item_type;

   // One result transaction, last field in the lowest bits
   typedef struct packed {
      logic [SEQ_OUT_BITS-1:0] seq_no;
      logic                    tx_has_packet;
      logic                    tx_fetch;
      logic                    period_received;
      logic                    period_done;
      logic                    deletable;
      logic [1:0]              sme_kind;
      logic [2:0]              status;
   } result_type;

endpackage

`default_nettype wire

// ===== design/slc_input_stage.sv =====
`default_nettype none

module slc_input_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire slc_pkg::req_item_type req_item,
   input  wire logic                 advance,
   output logic                      item_valid,
   output slc_pkg::req_item_type     item
);

   logic                  valid_ff;
   logic                  valid_in;
   slc_pkg::req_item_type item_ff;
   logic                  take;

   // Accept a new transaction when empty or when the held one moves on
   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the payload; no reset needed
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// ===== design/slc_event_core.sv =====
`default_nettype none

module slc_event_core #(
   parameter int unsigned SEQ_BITS = slc_pkg::SEQ_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wen,
   input  wire logic [slc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [slc_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  wire slc_pkg::req_item_type               item,
   input  wire logic                                advance,
   output slc_pkg::result_type                      result_in
);

   // Configuration
   logic [slc_pkg::CSR_DATA_BITS-1:0] retry_period_ff;
   logic [slc_pkg::CSR_DATA_BITS-1:0] give_up_period_ff;

   // Stream state
   slc_pkg::status_type   status_ff,        status_in;
   slc_pkg::timer_type    retry_timer_ff,   retry_timer_in;
   slc_pkg::timer_type    give_up_timer_ff, give_up_timer_in;
   logic [1:0]            rx_slot_count_ff, rx_slot_count_in;
   logic [1:0]            tx_slot_count_ff, tx_slot_count_in;
   logic [1:0]            slots_ff,         slots_in;
   logic                  got_packet_ff,    got_packet_in;
   logic                  tx_latched_ff,    tx_latched_in;
   logic [SEQ_BITS-1:0]   sequence_ff,      sequence_in;

   slc_pkg::timer_type    retry_reload;
   slc_pkg::timer_type    give_up_reload;
   slc_pkg::timer_type    retry_dec;
   slc_pkg::timer_type    give_up_dec;
   logic [1:0]            rx_next;
   logic [1:0]            tx_next;
   logic                  rx_gp;
   logic [31:0]           seq_wide;

   function automatic logic not_positive(slc_pkg::timer_type v);
      return v[8] || (v == '0);
   endfunction

   assign retry_reload   = slc_pkg::timer_type'({1'b0, retry_period_ff});
   assign give_up_reload = slc_pkg::timer_type'({1'b0, give_up_period_ff});
   assign retry_dec      = retry_timer_ff - 9'sd1;
   assign give_up_dec    = give_up_timer_ff - 9'sd1;
   assign rx_next        = rx_slot_count_ff + 2'd1;
   assign tx_next        = tx_slot_count_ff + 2'd1;
   assign rx_gp          = got_packet_ff || (item.req_type == slc_pkg::REQ_RX_PACKET);

   // Work out the next state and the result of the held event
   always_comb begin
      status_in        = status_ff;
      retry_timer_in   = retry_timer_ff;
      give_up_timer_in = give_up_timer_ff;
      rx_slot_count_in = rx_slot_count_ff;
      tx_slot_count_in = tx_slot_count_ff;
      slots_in         = slots_ff;
      got_packet_in    = got_packet_ff;
      tx_latched_in    = tx_latched_ff;
      sequence_in      = sequence_ff;
      result_in        = '0;

      case (item.req_type)
         slc_pkg::REQ_CREATE: begin
            status_in = (item.start_status == slc_pkg::START_STATUS_INVALID) ?
                        slc_pkg::ST_FAILED : slc_pkg::status_type'(item.start_status);
            retry_timer_in   = retry_reload;
            give_up_timer_in = give_up_reload;
            rx_slot_count_in = '0;
            tx_slot_count_in = '0;
            slots_in         = slc_pkg::SLOTS_ONE;
            got_packet_in    = 1'b0;
            tx_latched_in    = 1'b0;
            sequence_in      = '0;
         end
         slc_pkg::REQ_CONNECT: begin
            result_in.sme_kind = slc_pkg::SME_CONNECT;
         end
         slc_pkg::REQ_ADDED: begin
            if (status_ff == slc_pkg::ST_CONNECTING) begin
               status_in = slc_pkg::ST_ESTABLISHED;
            end else if (status_ff == slc_pkg::ST_REMOTE_CLOSED) begin
               status_in = slc_pkg::ST_REOPENED;
            end
            case (item.redundancy_level) inside
               slc_pkg::RED_NONE: begin
                  slots_in = slc_pkg::SLOTS_ONE;
               end
               slc_pkg::RED_DOUBLE, slc_pkg::RED_DOUBLE_SPATIAL: begin
                  slots_in = slc_pkg::SLOTS_TWO;
               end
               slc_pkg::RED_TRIPLE, slc_pkg::RED_TRIPLE_SPATIAL: begin
                  slots_in = slc_pkg::SLOTS_THREE;
               end
               default: begin
                  slots_in = slots_ff;
               end
            endcase
         end
         slc_pkg::REQ_ACCEPTED: begin
            if (status_ff == slc_pkg::ST_ACCEPT_WAIT) begin
               status_in = slc_pkg::ST_ESTABLISHED;
            end
         end
         slc_pkg::REQ_REMOVED: begin
            if (status_ff inside {slc_pkg::ST_ACCEPT_WAIT, slc_pkg::ST_CLOSE_WAIT}) begin
               result_in.deletable = 1'b1;
            end else if (status_ff inside {slc_pkg::ST_ESTABLISHED,
                                           slc_pkg::ST_REOPENED}) begin
               status_in = slc_pkg::ST_REMOTE_CLOSED;
            end
         end
         slc_pkg::REQ_REJECTED: begin
            if (status_ff == slc_pkg::ST_CONNECTING) begin
               status_in = slc_pkg::ST_FAILED;
            end
         end
         slc_pkg::REQ_SERVER_CLOSED: begin
            if (status_ff == slc_pkg::ST_ACCEPT_WAIT) begin
               status_in          = slc_pkg::ST_CLOSE_WAIT;
               result_in.sme_kind = slc_pkg::SME_CLOSED;
            end
         end
         slc_pkg::REQ_CLOSE: begin
            case (status_ff)
               slc_pkg::ST_ESTABLISHED: begin
                  status_in          = slc_pkg::ST_CLOSE_WAIT;
                  result_in.sme_kind = slc_pkg::SME_CLOSED;
               end
               slc_pkg::ST_REMOTE_CLOSED: begin
                  result_in.deletable = 1'b1;
               end
               slc_pkg::ST_REOPENED: begin
                  status_in = slc_pkg::ST_CLOSE_WAIT;
               end
               slc_pkg::ST_CLOSE_WAIT: begin
                  result_in.sme_kind = slc_pkg::SME_CLOSED;
               end
               default: begin
                  status_in = status_ff;
               end
            endcase
         end
         slc_pkg::REQ_TICK: begin
            // Run the retry and give-up timers while connecting, the retry timer alone while reopened or closing
            case (status_ff)
               slc_pkg::ST_CONNECTING: begin
                  if (not_positive(give_up_dec)) begin
                     retry_timer_in     = retry_reload;
                     give_up_timer_in   = give_up_reload;
                     status_in          = slc_pkg::ST_FAILED;
                     result_in.sme_kind = slc_pkg::SME_CLOSED;
                  end else if (not_positive(retry_dec)) begin
                     retry_timer_in     = retry_reload;
                     give_up_timer_in   = give_up_dec;
                     result_in.sme_kind = slc_pkg::SME_CONNECT;
                  end else begin
                     retry_timer_in   = retry_dec;
                     give_up_timer_in = give_up_dec;
                  end
               end
               slc_pkg::ST_REOPENED, slc_pkg::ST_CLOSE_WAIT: begin
                  if (not_positive(retry_timer_ff)) begin
                     retry_timer_in     = retry_reload;
                     result_in.sme_kind = slc_pkg::SME_CLOSED;
                  end else begin
                     retry_timer_in = retry_dec;
                  end
               end
               default: begin
                  retry_timer_in = retry_timer_ff;
               end
            endcase
         end
         slc_pkg::REQ_DESYNC: begin
            if (status_ff == slc_pkg::ST_CONNECTING) begin
               status_in = slc_pkg::ST_FAILED;
            end else if (status_ff inside {slc_pkg::ST_ACCEPT_WAIT,
                                           slc_pkg::ST_CLOSE_WAIT}) begin
               result_in.deletable = 1'b1;
            end else if (status_ff inside {slc_pkg::ST_ESTABLISHED,
                                           slc_pkg::ST_REOPENED}) begin
               status_in = slc_pkg::ST_REMOTE_CLOSED;
            end
         end
         slc_pkg::REQ_TX_SLOT: begin
            // Latch the packet flag on the first slot of a period
            if (tx_slot_count_ff == '0) begin
               result_in.tx_fetch = 1'b1;
               tx_latched_in      = item.app_packet_ready;
            end
            if (tx_next == '0 || tx_next >= slots_ff) begin
               tx_slot_count_in = '0;
               sequence_in      = sequence_ff + 1'b1;
            end else begin
               tx_slot_count_in = tx_next;
            end
            result_in.tx_has_packet = tx_latched_in;
         end
         slc_pkg::REQ_RX_PACKET, slc_pkg::REQ_RX_MISS: begin
            // Close the receive period after its last slot
            if (rx_next == '0 || rx_next >= slots_ff) begin
               rx_slot_count_in          = '0;
               sequence_in               = sequence_ff + 1'b1;
               result_in.period_done     = 1'b1;
               result_in.period_received = rx_gp;
               got_packet_in             = 1'b0;
            end else begin
               rx_slot_count_in = rx_next;
               got_packet_in    = rx_gp;
            end
         end
         default: begin
            status_in = status_ff;
         end
      endcase

      seq_wide         = 32'(sequence_in);
      result_in.status = status_in;
      result_in.seq_no = seq_wide[slc_pkg::SEQ_OUT_BITS-1:0];
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         retry_period_ff   <= slc_pkg::RETRY_PERIOD_RESET;
         give_up_period_ff <= slc_pkg::GIVE_UP_PERIOD_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            slc_pkg::CSR_RETRY_PERIOD: begin
               retry_period_ff <= csr_wdata;
            end
            slc_pkg::CSR_GIVE_UP_PERIOD: begin
               give_up_period_ff <= csr_wdata;
            end
            default: begin
               retry_period_ff <= retry_period_ff;
            end
         endcase
      end
   end

   // Commit state when the event moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff        <= slc_pkg::ST_CONNECTING;
         retry_timer_ff   <= '0;
         give_up_timer_ff <= '0;
         rx_slot_count_ff <= '0;
         tx_slot_count_ff <= '0;
         slots_ff         <= slc_pkg::SLOTS_ONE;
         got_packet_ff    <= 1'b0;
         tx_latched_ff    <= 1'b0;
         sequence_ff      <= '0;
      end else if (advance) begin
         status_ff        <= status_in;
         retry_timer_ff   <= retry_timer_in;
         give_up_timer_ff <= give_up_timer_in;
         rx_slot_count_ff <= rx_slot_count_in;
         tx_slot_count_ff <= tx_slot_count_in;
         slots_ff         <= slots_in;
         got_packet_ff    <= got_packet_in;
         tx_latched_ff    <= tx_latched_in;
         sequence_ff      <= sequence_in;
      end
   end

`ifndef ASSERT_OFF
   // Connect failed is left only by a new create
   a_failed_sticks: assert property (@(posedge clock) disable iff (reset)
      (advance && status_ff == slc_pkg::ST_FAILED && item.req_type != slc_pkg::REQ_CREATE)
      |=> (status_ff == slc_pkg::ST_FAILED))
      else $error("failed status left without create");

   // A completed receive period restarts the slot count
   a_rx_period_restart: assert property (@(posedge clock) disable iff (reset)
      (advance && result_in.period_done) |=> (rx_slot_count_ff == '0))
      else $error("rx slot count not cleared at end of period");

   // The sequence only moves with a processed transaction
   a_seq_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(sequence_ff))
      else $error("sequence changed without a transaction");
`endif

endmodule

`default_nettype wire

// ===== design/slc_output_stage.sv =====
`default_nettype none

module slc_output_stage (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire slc_pkg::result_type result_in,
   output logic                     free,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output slc_pkg::result_type      result
);

   logic                valid_ff;
   logic                valid_in;
   slc_pkg::result_type result_ff;

   // Room for a new result when empty or when the held one is taken now
   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign result     = result_ff;

endmodule

`default_nettype wire

// ===== design/stream_lifecycle_controller.sv =====
// Accepted events wait in the input register; rsp_ shows results from the result register.
// Throughput: one event per clock while rsp_ is not stalled; the state update is one pass
//   between the input register and the result register, so events may follow back to back.
// Reset: synchronous, active high; clears both valid flags and resets the stream state
//   and the configuration registers (retry 10, give-up 60 ticks).
`default_nettype none

module stream_lifecycle_controller #(
   parameter int unsigned SEQ_BITS = slc_pkg::SEQ_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Input events
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [2:0] start_status, [5:3] redundancy_level, [6] app_packet_ready, [7] zero
   input  wire logic [slc_pkg::REQ_TDATA_BITS-1:0]  req_tdata,
   // [3:0] req_type
   input  wire logic [slc_pkg::REQ_TUSER_BITS-1:0]  req_tuser,
   // Results
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [2:0] status, [4:3] sme_kind, [5] deletable, [6] period_done,
   // [7] period_received, [8] tx_fetch, [9] tx_has_packet, [25:10] seq_no,
   // [31:26] zero
   output logic [slc_pkg::RSP_TDATA_BITS-1:0]       rsp_tdata,
   // Configuration writes
   input  wire logic                                csr_wen,
   input  wire logic [slc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [slc_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   slc_pkg::req_item_type req_item;
   slc_pkg::req_item_type item;
   slc_pkg::result_type   result_in;
   slc_pkg::result_type   result;
   logic                  item_valid;
   logic                  out_free;
   logic                  advance;

   // Unpack the input transaction
   assign req_item.req_type         = req_tuser;
   assign req_item.app_packet_ready = req_tdata[6];
   assign req_item.redundancy_level = req_tdata[5:3];
   assign req_item.start_status     = req_tdata[2:0];

   // Move the held event on when the result register has room
   assign advance = item_valid && out_free;

   slc_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   slc_event_core #(
      .SEQ_BITS (SEQ_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .item      (item),
      .advance   (advance),
      .result_in (result_in)
   );

   slc_output_stage u_output (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result_in  (result_in),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .result     (result)
   );

   // Pack the result, padded to whole bytes
   assign rsp_tdata = slc_pkg::RSP_TDATA_BITS'(result);

endmodule

`default_nettype wire

// ===== test/stream_lifecycle_controller_tb.sv =====
`timescale 1ns / 100ps

module stream_lifecycle_controller_tb;

   localparam int unsigned CYCLE_LIMIT      = 1_000_000;
   localparam int unsigned RANDOM_PER_PHASE = 250;
   localparam int unsigned SETTLE_CYCLES    = 3;
   localparam int unsigned REPORT_LIMIT     = 10;

   // Event codes the block does not know, and a redundancy level it does not know
   localparam logic [3:0] REQ_UNKNOWN_LOW  = 4'd13;
   localparam logic [3:0] REQ_UNKNOWN_HIGH = 4'd15;
   localparam logic [2:0] RED_UNKNOWN_MAX  = 3'd7;

   // Holds the stream state as the block should see it and the reports still owed
   class stream_report_board;
      logic [slc_pkg::CSR_DATA_BITS-1:0] retry_period;
      logic [slc_pkg::CSR_DATA_BITS-1:0] give_up_period;
      slc_pkg::status_type               status_q;
      int                                retry_left;
      int                                give_up_left;
      logic [1:0]                        rx_count;
      logic [1:0]                        tx_count;
      logic [1:0]                        period_len;
      bit                                got_pkt;
      bit                                tx_pkt;
      logic [slc_pkg::SEQ_OUT_BITS-1:0]  seq;
      slc_pkg::result_type               expected_reports[$];
      int unsigned                       mismatch_count;

      function new();
         retry_period   = slc_pkg::RETRY_PERIOD_RESET;
         give_up_period = slc_pkg::GIVE_UP_PERIOD_RESET;
         status_q       = slc_pkg::ST_CONNECTING;
         retry_left     = 0;
         give_up_left   = 0;
         rx_count       = 2'd0;
         tx_count       = 2'd0;
         period_len     = slc_pkg::SLOTS_ONE;
         got_pkt        = 1'b0;
         tx_pkt         = 1'b0;
         seq            = '0;
         mismatch_count = 0;
      endfunction

      function void set_register(logic [slc_pkg::CSR_INDEX_BITS-1:0] index,
                                 logic [slc_pkg::CSR_DATA_BITS-1:0] value);
         if (index == slc_pkg::CSR_RETRY_PERIOD) begin
            retry_period = value;
         end else begin
            give_up_period = value;
         end
      endfunction

      function int unsigned outstanding();
         return expected_reports.size();
      endfunction

      // Advance the retry and give-up timers by one period tick
      function slc_pkg::sme_type period_tick();
         case (status_q)
            slc_pkg::ST_CONNECTING: begin
               retry_left--;
               give_up_left--;
               if (give_up_left <= 0) begin
                  retry_left   = int'(retry_period);
                  give_up_left = int'(give_up_period);
                  status_q     = slc_pkg::ST_FAILED;
                  return slc_pkg::SME_CLOSED;
               end
               if (retry_left <= 0) begin
                  retry_left = int'(retry_period);
                  return slc_pkg::SME_CONNECT;
               end
               return slc_pkg::SME_NONE;
            end
            slc_pkg::ST_REOPENED, slc_pkg::ST_CLOSE_WAIT: begin
               if (retry_left <= 0) begin
                  retry_left = int'(retry_period);
                  return slc_pkg::SME_CLOSED;
               end
               retry_left--;
               return slc_pkg::SME_NONE;
            end
            default: return slc_pkg::SME_NONE;
         endcase
      endfunction

      // Work out the report for one accepted event and queue it
      function void note_event(logic [3:0] kind, logic [2:0] start, logic [2:0] level,
                               logic ready);
         slc_pkg::result_type want;
         want = '0;
         case (kind)
            slc_pkg::REQ_CREATE: begin
               status_q     = (start == slc_pkg::START_STATUS_INVALID) ?
                              slc_pkg::ST_FAILED : slc_pkg::status_type'(start);
               retry_left   = int'(retry_period);
               give_up_left = int'(give_up_period);
               rx_count     = 2'd0;
               tx_count     = 2'd0;
               period_len   = slc_pkg::SLOTS_ONE;
               got_pkt      = 1'b0;
               tx_pkt       = 1'b0;
               seq          = '0;
            end
            slc_pkg::REQ_CONNECT: want.sme_kind = slc_pkg::SME_CONNECT;
            slc_pkg::REQ_ADDED: begin
               if (status_q == slc_pkg::ST_CONNECTING) begin
                  status_q = slc_pkg::ST_ESTABLISHED;
               end else if (status_q == slc_pkg::ST_REMOTE_CLOSED) begin
                  status_q = slc_pkg::ST_REOPENED;
               end
               if (level == slc_pkg::RED_NONE) begin
                  period_len = slc_pkg::SLOTS_ONE;
               end else if (level == slc_pkg::RED_DOUBLE ||
                            level == slc_pkg::RED_DOUBLE_SPATIAL) begin
                  period_len = slc_pkg::SLOTS_TWO;
               end else if (level == slc_pkg::RED_TRIPLE ||
                            level == slc_pkg::RED_TRIPLE_SPATIAL) begin
                  period_len = slc_pkg::SLOTS_THREE;
               end
            end
            slc_pkg::REQ_ACCEPTED: begin
               if (status_q == slc_pkg::ST_ACCEPT_WAIT) status_q = slc_pkg::ST_ESTABLISHED;
            end
            slc_pkg::REQ_REMOVED: begin
               if (status_q == slc_pkg::ST_ACCEPT_WAIT ||
                   status_q == slc_pkg::ST_CLOSE_WAIT) begin
                  want.deletable = 1'b1;
               end else if (status_q == slc_pkg::ST_ESTABLISHED ||
                            status_q == slc_pkg::ST_REOPENED) begin
                  status_q = slc_pkg::ST_REMOTE_CLOSED;
               end
            end
            slc_pkg::REQ_REJECTED: begin
               if (status_q == slc_pkg::ST_CONNECTING) status_q = slc_pkg::ST_FAILED;
            end
            slc_pkg::REQ_SERVER_CLOSED: begin
               if (status_q == slc_pkg::ST_ACCEPT_WAIT) begin
                  status_q      = slc_pkg::ST_CLOSE_WAIT;
                  want.sme_kind = slc_pkg::SME_CLOSED;
               end
            end
            slc_pkg::REQ_CLOSE: begin
               case (status_q)
                  slc_pkg::ST_ESTABLISHED: begin
                     status_q      = slc_pkg::ST_CLOSE_WAIT;
                     want.sme_kind = slc_pkg::SME_CLOSED;
                  end
                  slc_pkg::ST_REMOTE_CLOSED: want.deletable = 1'b1;
                  slc_pkg::ST_REOPENED:      status_q = slc_pkg::ST_CLOSE_WAIT;
                  slc_pkg::ST_CLOSE_WAIT:    want.sme_kind = slc_pkg::SME_CLOSED;
                  default: ;
               endcase
            end
            slc_pkg::REQ_TICK: want.sme_kind = period_tick();
            slc_pkg::REQ_DESYNC: begin
               if (status_q == slc_pkg::ST_CONNECTING) begin
                  status_q = slc_pkg::ST_FAILED;
               end else if (status_q == slc_pkg::ST_ACCEPT_WAIT ||
                            status_q == slc_pkg::ST_CLOSE_WAIT) begin
                  want.deletable = 1'b1;
               end else if (status_q == slc_pkg::ST_ESTABLISHED ||
                            status_q == slc_pkg::ST_REOPENED) begin
                  status_q = slc_pkg::ST_REMOTE_CLOSED;
               end
            end
            slc_pkg::REQ_TX_SLOT: begin
               // Latch the application's packet on the first slot of a period
               if (tx_count == 2'd0) begin
                  want.tx_fetch = 1'b1;
                  tx_pkt        = ready;
               end
               tx_count = tx_count + 2'd1;
               if (tx_count == 2'd0 || tx_count >= period_len) begin
                  tx_count = 2'd0;
                  seq      = seq + 1'b1;
               end
               want.tx_has_packet = tx_pkt;
            end
            slc_pkg::REQ_RX_PACKET, slc_pkg::REQ_RX_MISS: begin
               if (kind == slc_pkg::REQ_RX_PACKET) got_pkt = 1'b1;
               rx_count = rx_count + 2'd1;
               if (rx_count == 2'd0 || rx_count >= period_len) begin
                  rx_count             = 2'd0;
                  seq                  = seq + 1'b1;
                  want.period_done     = 1'b1;
                  want.period_received = got_pkt;
                  got_pkt              = 1'b0;
               end
            end
            default: ;
         endcase
         want.status = status_q;
         want.seq_no = seq;
         expected_reports = {expected_reports, want};
      endfunction

      function void report(string text);
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) $display("%s", text);
      endfunction

      // Compare one result transaction with the oldest report owed
      function void check_report(logic [slc_pkg::RSP_TDATA_BITS-1:0] data);
         slc_pkg::result_type got;
         slc_pkg::result_type want;
         got = data[$bits(slc_pkg::result_type)-1:0];
         if (expected_reports.size() == 0) begin
            report($sformatf("result with no event outstanding: status %0d seq_no %0d",
                             got.status, got.seq_no));
            return;
         end
         want = expected_reports[0];
         expected_reports.delete(0);
         if (got.status !== want.status)
            report($sformatf("status: expected %0d, got %0d", want.status, got.status));
         if (got.sme_kind !== want.sme_kind)
            report($sformatf("sme_kind: expected %0d, got %0d", want.sme_kind, got.sme_kind));
         if (got.deletable !== want.deletable)
            report($sformatf("deletable: expected %0d, got %0d", want.deletable,
                             got.deletable));
         if (got.period_done !== want.period_done)
            report($sformatf("period_done: expected %0d, got %0d", want.period_done,
                             got.period_done));
         if (got.period_received !== want.period_received)
            report($sformatf("period_received: expected %0d, got %0d",
                             want.period_received, got.period_received));
         if (got.tx_fetch !== want.tx_fetch)
            report($sformatf("tx_fetch: expected %0d, got %0d", want.tx_fetch, got.tx_fetch));
         if (got.tx_has_packet !== want.tx_has_packet)
            report($sformatf("tx_has_packet: expected %0d, got %0d", want.tx_has_packet,
                             got.tx_has_packet));
         if (got.seq_no !== want.seq_no)
            report($sformatf("seq_no: expected %0d, got %0d", want.seq_no, got.seq_no));
      endfunction
   endclass

   logic                                 clock      = 1'b0;
   logic                                 reset      = 1'b1;
   logic                                 req_tvalid = 1'b0;
   logic                                 req_tready;
   // [2:0] start_status, [5:3] redundancy_level, [6] app_packet_ready, [7] zero
   logic [slc_pkg::REQ_TDATA_BITS-1:0]   req_tdata  = '0;
   // [3:0] req_type
   logic [slc_pkg::REQ_TUSER_BITS-1:0]   req_tuser  = '0;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   // [2:0] status, [4:3] sme_kind, [5] deletable, [6] period_done,
   // [7] period_received, [8] tx_fetch, [9] tx_has_packet, [25:10] seq_no
   logic [slc_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata;
   logic                                 csr_wen    = 1'b0;
   logic [slc_pkg::CSR_INDEX_BITS-1:0]   csr_index  = '0;
   logic [slc_pkg::CSR_DATA_BITS-1:0]    csr_wdata  = '0;

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   int unsigned cycle_count   = 0;

   stream_report_board books;

   stream_lifecycle_controller u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Check each result transaction and stall the result channel at random
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) books.check_report(rsp_tdata);
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Give up on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Offer one event, with random idle cycles ahead of it, and hold until accepted
   task automatic send_event(input logic [3:0] kind, input logic [2:0] start,
                             input logic [2:0] level, input logic ready);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {1'b0, ready, level, start};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      books.note_event(kind, start, level, ready);
   endtask

   // Drop valid and wait until every report has arrived and the block is quiet
   task automatic drain();
      req_tvalid <= 1'b0;
      while (books.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_csr(input logic [slc_pkg::CSR_INDEX_BITS-1:0] index,
                              input logic [slc_pkg::CSR_DATA_BITS-1:0] value);
      drain();
      csr_wen   <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen   <= 1'b0;
      books.set_register(index, value);
   endtask

   // Mostly meaningful lifecycle traffic, with slots and ticks dominating
   task automatic random_event();
      int unsigned pick;
      logic [3:0]  kind;
      logic [2:0]  start;
      logic [2:0]  level;
      logic        ready;
      pick  = $urandom_range(99);
      start = 3'($urandom_range(7));
      level = 3'($urandom_range(7));
      ready = 1'($urandom_range(1));
      if (pick < 5)       kind = slc_pkg::REQ_CREATE;
      else if (pick < 10) kind = slc_pkg::REQ_CONNECT;
      else if (pick < 15) kind = slc_pkg::REQ_ADDED;
      else if (pick < 19) kind = slc_pkg::REQ_ACCEPTED;
      else if (pick < 24) kind = slc_pkg::REQ_REMOVED;
      else if (pick < 27) kind = slc_pkg::REQ_REJECTED;
      else if (pick < 31) kind = slc_pkg::REQ_SERVER_CLOSED;
      else if (pick < 37) kind = slc_pkg::REQ_CLOSE;
      else if (pick < 60) kind = slc_pkg::REQ_TICK;
      else if (pick < 63) kind = slc_pkg::REQ_DESYNC;
      else if (pick < 75) kind = slc_pkg::REQ_TX_SLOT;
      else if (pick < 86) kind = slc_pkg::REQ_RX_PACKET;
      else if (pick < 97) kind = slc_pkg::REQ_RX_MISS;
      else                kind = 4'($urandom_range(REQ_UNKNOWN_HIGH, REQ_UNKNOWN_LOW));
      send_event(kind, start, level, ready);
   endtask

   task automatic run_phase(input logic [slc_pkg::CSR_DATA_BITS-1:0] retry,
                            input logic [slc_pkg::CSR_DATA_BITS-1:0] give_up,
                            input int unsigned send_pct, input int unsigned hold_pct);
      program_csr(slc_pkg::CSR_RETRY_PERIOD, retry);
      program_csr(slc_pkg::CSR_GIVE_UP_PERIOD, give_up);
      send_idle_pct = send_pct;
      stall_pct     = hold_pct;
      repeat (RANDOM_PER_PHASE) random_event();
   endtask

   initial begin
      books = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed walk through the lifecycle at the reset periods
      send_event(slc_pkg::REQ_CREATE, slc_pkg::ST_CONNECTING, slc_pkg::RED_NONE, 1'b0);
      send_event(slc_pkg::REQ_CONNECT, slc_pkg::ST_CONNECTING, slc_pkg::RED_NONE, 1'b0);
      send_event(slc_pkg::REQ_TICK, slc_pkg::ST_CONNECTING, slc_pkg::RED_NONE, 1'b0);
      send_event(slc_pkg::REQ_ADDED, slc_pkg::ST_CONNECTING, slc_pkg::RED_TRIPLE_SPATIAL,
                 1'b0);
      send_event(slc_pkg::REQ_TX_SLOT, slc_pkg::ST_CONNECTING, slc_pkg::RED_NONE, 1'b1);
      send_event(slc_pkg::REQ_TX_SLOT, slc_pkg::ST_CONNECTING, slc_pkg::RED_NONE, 1'b0);
      send_event(slc_pkg::REQ_RX_PACKET, slc_pkg::ST_CONNECTING, slc_pkg::RED_NONE, 1'b0);
      send_event(slc_pkg::REQ_RX_MISS, slc_pkg::ST_CONNECTING, slc_pkg::RED_NONE, 1'b0);
      // Shorten the period while the receive counter is already past it
      send_event(slc_pkg::REQ_ADDED, slc_pkg::ST_CONNECTING, slc_pkg::RED_NONE, 1'b0);
      send_event(slc_pkg::REQ_RX_MISS, slc_pkg::ST_CONNECTING, slc_pkg::RED_NONE, 1'b0);
      send_event(slc_pkg::REQ_TX_SLOT, slc_pkg::ST_CONNECTING, slc_pkg::RED_NONE, 1'b1);
      send_event(slc_pkg::REQ_DESYNC, slc_pkg::ST_CONNECTING, slc_pkg::RED_NONE, 1'b0);
      send_event(slc_pkg::REQ_ADDED, slc_pkg::ST_CONNECTING, RED_UNKNOWN_MAX, 1'b0);
      send_event(slc_pkg::REQ_CLOSE, slc_pkg::ST_CONNECTING, slc_pkg::RED_NONE, 1'b0);
      send_event(slc_pkg::REQ_TICK, slc_pkg::ST_CONNECTING, slc_pkg::RED_NONE, 1'b0);
      send_event(slc_pkg::REQ_REMOVED, slc_pkg::ST_CONNECTING, slc_pkg::RED_NONE, 1'b0);
      send_event(slc_pkg::REQ_CREATE, slc_pkg::ST_ACCEPT_WAIT, RED_UNKNOWN_MAX, 1'b1);
      send_event(slc_pkg::REQ_SERVER_CLOSED, slc_pkg::ST_CONNECTING, slc_pkg::RED_NONE,
                 1'b0);
      send_event(slc_pkg::REQ_CREATE, slc_pkg::START_STATUS_INVALID, slc_pkg::RED_NONE,
                 1'b0);
      send_event(slc_pkg::REQ_REJECTED, slc_pkg::ST_CONNECTING, slc_pkg::RED_NONE, 1'b0);
      send_event(slc_pkg::REQ_ACCEPTED, slc_pkg::ST_CONNECTING, slc_pkg::RED_NONE, 1'b0);
      for (int k = REQ_UNKNOWN_LOW; k <= REQ_UNKNOWN_HIGH; k++)
         send_event(4'(k), slc_pkg::START_STATUS_INVALID, RED_UNKNOWN_MAX, 1'b1);
      send_event(slc_pkg::REQ_CREATE, slc_pkg::ST_ESTABLISHED, slc_pkg::RED_NONE, 1'b0);
      send_event(slc_pkg::REQ_CLOSE, slc_pkg::ST_CONNECTING, slc_pkg::RED_NONE, 1'b0);

      // Random traffic under different periods and handshake pressure
      run_phase(8'd0, 8'd255, 0, 0);
      run_phase(8'd255, 8'd0, 50, 0);
      run_phase(8'd2, 8'd5, 0, 50);
      run_phase(8'd3, 8'd7, 32, 32);

      drain();
      if (books.mismatch_count == 0 && books.outstanding() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
